[hdl/multilevel_priority_scheduler_unit_assert.svh]
// Assertion macros shared by the scheduler RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef MULTILEVEL_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSCHED_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MSCHED_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

[hdl/msched_pkg.sv]
package msched_pkg;

  // Width of one slice examined by the bit scanner per cycle.
  localparam int SCAN_CHUNK = 16;
  localparam int SCAN_POS_W = $clog2(SCAN_CHUNK);
  // Scanner index width, wide enough for the largest id space.
  localparam int SCAN_IDX_W = 10;

  // Port field widths.
  localparam int ID_PORT_W   = 6;
  localparam int PRIO_PORT_W = 6;
  localparam int LIFE_W      = 3;

  localparam logic [LIFE_W-1:0] LIFE_MIN = 3'd1;
  localparam logic [LIFE_W-1:0] LIFE_MAX = 3'd5;

  // Operation codes carried on the op port.
  typedef enum logic {
    OP_CREATE = 1'b0,
    OP_RUN    = 1'b1
  } op_t;

  // Result of one scan pass.
  typedef struct packed {
    logic                  done;
    logic                  hit;
    logic [SCAN_IDX_W-1:0] index;
  } scan_res_t;

endpackage

[hdl/msched_scan.sv]
module msched_scan
  import msched_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WIDTH-1:0] vec,
  output scan_res_t        res
);

  localparam int NCHUNK = (WIDTH + SCAN_CHUNK - 1) / SCAN_CHUNK;
  localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = NCHUNK * SCAN_CHUNK;

  logic                  scanning;
  logic [CNT_W-1:0]      chunk;
  logic [PAD_W-1:0]      pad;
  logic [SCAN_CHUNK-1:0] slice;
  logic [SCAN_CHUNK-1:0] low;
  logic [SCAN_POS_W-1:0] pos;
  logic                  last;
  logic                  hit;

  // Isolate the lowest set bit of the current slice and encode its position.
  always_comb begin
    pad   = PAD_W'(vec);
    slice = pad[chunk*SCAN_CHUNK +: SCAN_CHUNK];
    low   = slice & (~slice + 1'b1);
    hit   = |slice;
    last  = (chunk == CNT_W'(NCHUNK - 1));
    pos   = '0;
    for (int i = 0; i < SCAN_CHUNK; i++) begin
      if (low[i]) begin
        pos = pos | SCAN_POS_W'(i);
      end
    end
  end

  assign res.done  = scanning && (hit || last);
  assign res.hit   = hit;
  assign res.index = SCAN_IDX_W'({chunk, pos});

  // One slice per cycle, lowest slice first.
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      chunk    <= '0;
    end else if (!scanning) begin
      if (go) begin
        scanning <= 1'b1;
        chunk    <= '0;
      end
    end else if (hit || last) begin
      scanning <= 1'b0;
    end else begin
      chunk <= chunk + 1'b1;
    end
  end

endmodule

[hdl/multilevel_priority_scheduler_unit.sv]
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// input    | start, busy         | op, new_priority, new_life
// result   | done (1-cycle pulse)| failed, task_id, old_priority, new_priority_res,
//          |                     | life_left, retired
//
// A transaction is taken when start is high and busy is low; busy stays high
// until its result has been issued. One 16-bit bit scanner is reused for the
// free-id search and the highest-level search, one slice per cycle, at most
// ceil(max(ID_COUNT, NUM_LEVELS)/16) slices in all. A run with every queue empty
// fails without raising busy. rst is synchronous and frees every id and empties
// every queue at once. Results cannot be stalled by the receiver.
`include "multilevel_priority_scheduler_unit_assert.svh"

module multilevel_priority_scheduler_unit
  import msched_pkg::*;
#(
  parameter int NUM_LEVELS = 50,
  parameter int ID_COUNT   = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op,
  input  logic [PRIO_PORT_W-1:0] new_priority,
  input  logic [LIFE_W-1:0]      new_life,
  output logic                   done,
  output logic                   failed,
  output logic [ID_PORT_W-1:0]   task_id,
  output logic [PRIO_PORT_W-1:0] old_priority,
  output logic [PRIO_PORT_W-1:0] new_priority_res,
  output logic [LIFE_W-1:0]      life_left,
  output logic                   retired
);

  localparam int ID_W   = $clog2(ID_COUNT);
  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SCAN_W = (ID_COUNT > NUM_LEVELS) ? ID_COUNT : NUM_LEVELS;
  localparam int IDX_W  = $clog2(SCAN_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND_ID,
    S_FIND_LVL,
    S_RD_HT,
    S_RD_TASK,
    S_APP0,
    S_APP1
  } state_t;

  state_t                state;
  logic [ID_COUNT-1:0]   id_used;
  logic [NUM_LEVELS-1:0] level_nonempty;
  logic [LVL_W-1:0]      cur_prio;
  logic [LIFE_W-1:0]     cur_life;
  logic [ID_W-1:0]       cur_id;
  logic [LVL_W-1:0]      cur_lvl;
  logic                  same_ht;
  logic [ID_W-1:0]       res_id;

  // Linked-list stores.
  logic [ID_W-1:0]   head_mem [NUM_LEVELS];
  logic [ID_W-1:0]   tail_mem [NUM_LEVELS];
  logic [ID_W-1:0]   link_mem [ID_COUNT];
  logic [LVL_W-1:0]  prio_mem [ID_COUNT];
  logic [LIFE_W-1:0] life_mem [ID_COUNT];

  logic [ID_W-1:0]   head_q;
  logic [ID_W-1:0]   tail_q;
  logic [ID_W-1:0]   link_q;
  logic [LVL_W-1:0]  prio_q;
  logic [LIFE_W-1:0] life_q;

  logic [LVL_W-1:0]  ht_raddr;
  logic              head_we;
  logic              tail_we;
  logic [LVL_W-1:0]  ht_waddr;
  logic [ID_W-1:0]   head_wdata;
  logic              link_we;
  logic [ID_W-1:0]   link_waddr;
  logic [ID_W-1:0]   link_wdata;
  logic              task_we;
  logic [ID_W-1:0]   task_waddr;
  logic [LVL_W-1:0]  prio_wdata;
  logic [LIFE_W-1:0] life_wdata;

  logic [SCAN_W-1:0] id_vec;
  logic [SCAN_W-1:0] lvl_vec;
  logic [SCAN_W-1:0] scan_vec;
  logic              scan_go;
  scan_res_t         scan;
  logic [IDX_W-1:0]  scan_idx;
  logic [ID_W-1:0]   scan_id;
  logic [LVL_W-1:0]  scan_lvl;

  logic [LVL_W-1:0]  clamp_prio;
  logic [LIFE_W-1:0] clamp_life;
  logic [LVL_W-1:0]  half_prio;
  logic [LIFE_W-1:0] life_dec;

  assign busy = (state != S_IDLE);

  // Input clamping of a create transaction.
  always_comb begin
    if (7'(new_priority) >= 7'(NUM_LEVELS)) begin
      clamp_prio = LVL_W'(NUM_LEVELS - 1);
    end else begin
      clamp_prio = LVL_W'(new_priority);
    end
    if (new_life == '0) begin
      clamp_life = LIFE_MIN;
    end else if (new_life > LIFE_MAX) begin
      clamp_life = LIFE_MAX;
    end else begin
      clamp_life = new_life;
    end
  end

  // Aging of the task read back on a run.
  assign half_prio = prio_q >> 1;
  assign life_dec  = (life_q != '0) ? life_q - 1'b1 : '0;

  // Scanner operands: free ids from the bottom, levels from the top.
  always_comb begin
    id_vec                = '0;
    id_vec[ID_COUNT-1:0]  = ~id_used;
    id_vec[0]             = 1'b0;
    lvl_vec               = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lvl_vec[i] = level_nonempty[NUM_LEVELS-1-i];
    end
    scan_vec = (state == S_FIND_LVL) ? lvl_vec : id_vec;
    scan_go  = (state == S_IDLE) && start &&
               ((op == OP_CREATE) || (level_nonempty != '0));
  end

  msched_scan #(
    .WIDTH (SCAN_W)
  ) u_scan (
    .clk (clk),
    .rst (rst),
    .go  (scan_go),
    .vec (scan_vec),
    .res (scan)
  );

  assign scan_idx = scan.index[IDX_W-1:0];
  assign scan_id  = ID_W'(scan_idx);
  assign scan_lvl = LVL_W'(IDX_W'(NUM_LEVELS - 1) - scan_idx);

  // Memory port control for each step of the sequencer.
  always_comb begin
    ht_raddr   = (state == S_FIND_LVL) ? scan_lvl : cur_prio;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    ht_waddr   = cur_prio;
    head_wdata = cur_id;
    link_we    = 1'b0;
    link_waddr = cur_id;
    link_wdata = '0;
    task_we    = 1'b0;
    task_waddr = cur_id;
    prio_wdata = half_prio;
    life_wdata = life_dec;
    unique case (state)
      S_FIND_ID: begin
        task_we    = scan.done && scan.hit;
        task_waddr = scan_id;
        prio_wdata = cur_prio;
        life_wdata = cur_life;
      end
      S_RD_TASK: begin
        head_we    = !same_ht;
        ht_waddr   = cur_lvl;
        head_wdata = link_q;
        task_we    = 1'b1;
      end
      S_APP0: begin
        link_we = 1'b1;
        head_we = !level_nonempty[cur_prio];
        tail_we = !level_nonempty[cur_prio];
      end
      S_APP1: begin
        link_we    = 1'b1;
        link_waddr = tail_q;
        link_wdata = cur_id;
        tail_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Level head and tail stores.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[ht_waddr] <= head_wdata;
    end
    if (tail_we) begin
      tail_mem[ht_waddr] <= cur_id;
    end
    head_q <= head_mem[ht_raddr];
    tail_q <= tail_mem[ht_raddr];
  end

  // Per-task link, priority and lifetime stores.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (task_we) begin
      prio_mem[task_waddr] <= prio_wdata;
      life_mem[task_waddr] <= life_wdata;
    end
    link_q <= link_mem[head_q];
    prio_q <= prio_mem[head_q];
    life_q <= life_mem[head_q];
  end

  // Sequencer, id map, level flags and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      id_used        <= '0;
      level_nonempty <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur_prio <= clamp_prio;
            cur_life <= clamp_life;
            if (op == OP_CREATE) begin
              state <= S_FIND_ID;
            end else if (level_nonempty == '0) begin
              done             <= 1'b1;
              failed           <= 1'b1;
              task_id          <= '0;
              old_priority     <= '0;
              new_priority_res <= '0;
              life_left        <= '0;
              retired          <= 1'b0;
            end else begin
              state <= S_FIND_LVL;
            end
          end
        end
        S_FIND_ID: begin
          if (scan.done) begin
            if (scan.hit) begin
              cur_id           <= scan_id;
              res_id           <= scan_id;
              id_used[scan_id] <= 1'b1;
              failed           <= 1'b0;
              task_id          <= ID_PORT_W'(scan_id);
              old_priority     <= PRIO_PORT_W'(cur_prio);
              new_priority_res <= PRIO_PORT_W'(cur_prio);
              life_left        <= cur_life;
              retired          <= 1'b0;
              state            <= S_APP0;
            end else begin
              done             <= 1'b1;
              failed           <= 1'b1;
              task_id          <= '0;
              old_priority     <= '0;
              new_priority_res <= '0;
              life_left        <= '0;
              retired          <= 1'b0;
              state            <= S_IDLE;
            end
          end
        end
        S_FIND_LVL: begin
          if (scan.done) begin
            cur_lvl <= scan_lvl;
            state   <= S_RD_HT;
          end
        end
        S_RD_HT: begin
          cur_id  <= head_q;
          same_ht <= (head_q == tail_q);
          state   <= S_RD_TASK;
        end
        S_RD_TASK: begin
          // Dequeue the head, then either requeue at the halved level or retire.
          if (same_ht) begin
            level_nonempty[cur_lvl] <= 1'b0;
          end
          cur_prio         <= half_prio;
          res_id           <= cur_id;
          failed           <= 1'b0;
          task_id          <= ID_PORT_W'(cur_id);
          old_priority     <= PRIO_PORT_W'(cur_lvl);
          new_priority_res <= PRIO_PORT_W'(half_prio);
          life_left        <= life_dec;
          retired          <= (life_dec == '0);
          if (life_dec == '0) begin
            id_used[cur_id] <= 1'b0;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            state <= S_APP0;
          end
        end
        S_APP0: begin
          if (level_nonempty[cur_prio]) begin
            state <= S_APP1;
          end else begin
            level_nonempty[cur_prio] <= 1'b1;
            done                     <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        S_APP1: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A task that was created or requeued must hold its id.
  `MSCHED_ASSERT_IMP(a_live_id_used, done && !failed && !retired, id_used[res_id])
  // A retired task must have given its id back.
  `MSCHED_ASSERT_IMP(a_retired_id_free, done && retired && !failed, !id_used[res_id])
  // The level search only starts with some queue filled, so it must hit.
  `MSCHED_ASSERT_IMP(a_lvl_scan_hits, (state == S_FIND_LVL) && scan.done, scan.hit)
  // Leaving the busy phase always issues a result.
  `MSCHED_ASSERT_IMP(a_result_on_exit, $fell(busy), done)
  // A create transaction always enters the busy phase.
  `MSCHED_ASSERT_NXT(a_create_busy, start && !busy && (op == OP_CREATE), busy)

endmodule

[bench/multilevel_priority_scheduler_unit_tb.sv]
module multilevel_priority_scheduler_unit_tb
  import msched_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 50;
  localparam int IDS = 64;
  localparam int TOTAL_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_PRINTED = 20;

  // Expected content of one result transaction.
  typedef struct packed {
    logic                   fail;
    logic [ID_PORT_W-1:0]   id;
    logic [PRIO_PORT_W-1:0] from_level;
    logic [PRIO_PORT_W-1:0] to_level;
    logic [LIFE_W-1:0]      life;
    logic                   retire;
  } sched_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   op = OP_CREATE;
  logic [PRIO_PORT_W-1:0] new_priority = '0;
  logic [LIFE_W-1:0]      new_life = '0;
  logic                   done;
  logic                   failed;
  logic [ID_PORT_W-1:0]   task_id;
  logic [PRIO_PORT_W-1:0] old_priority;
  logic [PRIO_PORT_W-1:0] new_priority_res;
  logic [LIFE_W-1:0]      life_left;
  logic                   retired;

  // Scheduler state as this bench tracks it. The ready order inside a level is
  // kept as an enqueue stamp per task instead of linked lists.
  bit                     task_live [IDS];
  logic [PRIO_PORT_W-1:0] task_level [IDS];
  logic [LIFE_W-1:0]      task_runs [IDS];
  int unsigned            task_stamp [IDS];
  int unsigned            stamp_next = 0;
  int                     live_count = 0;

  sched_result_t pending_results[$];

  int mismatch_count = 0;
  int sent_count = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int create_count = 0;
  int refused_creates = 0;
  int run_count = 0;
  int idle_runs = 0;
  int retire_count = 0;

  multilevel_priority_scheduler_unit #(
    .NUM_LEVELS(LEVELS),
    .ID_COUNT(IDS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .new_priority(new_priority),
    .new_life(new_life),
    .done(done),
    .failed(failed),
    .task_id(task_id),
    .old_priority(old_priority),
    .new_priority_res(new_priority_res),
    .life_left(life_left),
    .retired(retired)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the result of one accepted transaction and updates the tracked state.
  function automatic sched_result_t predict_schedule(op_t kind, logic [PRIO_PORT_W-1:0] prio_in,
                                                     logic [LIFE_W-1:0] life_in);
    sched_result_t r;
    int pick;
    logic [PRIO_PORT_W-1:0] lvl;
    logic [LIFE_W-1:0] runs;
    r = '0;
    pick = 0;
    if (kind == OP_CREATE) begin
      create_count++;
      lvl = (prio_in >= LEVELS) ? PRIO_PORT_W'(LEVELS - 1) : prio_in;
      if (life_in < LIFE_MIN) begin
        runs = LIFE_MIN;
      end else if (life_in > LIFE_MAX) begin
        runs = LIFE_MAX;
      end else begin
        runs = life_in;
      end
      // The lowest free id wins; id zero is never handed out.
      for (int i = IDS - 1; i >= 1; i--) begin
        if (!task_live[i]) pick = i;
      end
      if (pick == 0) begin
        r.fail = 1'b1;
        refused_creates++;
      end else begin
        task_live[pick] = 1'b1;
        task_level[pick] = lvl;
        task_runs[pick] = runs;
        task_stamp[pick] = stamp_next;
        stamp_next++;
        live_count++;
        r.id = ID_PORT_W'(pick);
        r.from_level = lvl;
        r.to_level = lvl;
        r.life = runs;
      end
    end else begin
      run_count++;
      // Highest level first, then the task that has waited longest there.
      for (int i = 1; i < IDS; i++) begin
        if (task_live[i]) begin
          if (pick == 0 || task_level[i] > task_level[pick] ||
              (task_level[i] == task_level[pick] && task_stamp[i] < task_stamp[pick])) begin
            pick = i;
          end
        end
      end
      if (pick == 0) begin
        r.fail = 1'b1;
        idle_runs++;
      end else begin
        lvl = task_level[pick] >> 1;
        runs = task_runs[pick] - 1'b1;
        r.id = ID_PORT_W'(pick);
        r.from_level = task_level[pick];
        r.to_level = lvl;
        r.life = runs;
        if (runs != 0) begin
          task_level[pick] = lvl;
          task_runs[pick] = runs;
          task_stamp[pick] = stamp_next;
          stamp_next++;
        end else begin
          task_live[pick] = 1'b0;
          live_count--;
          r.retire = 1'b1;
          retire_count++;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    end
  endtask

  // Sends one transaction, with bursts and random gaps on the input side.
  task automatic send_item(op_t kind, logic [PRIO_PORT_W-1:0] prio_in, logic [LIFE_W-1:0] life_in);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 9);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    op <= kind;
    new_priority <= prio_in;
    new_life <= life_in;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_schedule(kind, prio_in, life_in));
    sent_count++;
  endtask

  // Create with random content, mostly inside the legal ranges.
  task automatic send_random_create();
    logic [PRIO_PORT_W-1:0] p;
    p = ($urandom_range(0, 7) == 0) ? PRIO_PORT_W'($urandom_range(LEVELS, 63))
                                    : PRIO_PORT_W'($urandom_range(0, LEVELS - 1));
    send_item(OP_CREATE, p, LIFE_W'($urandom_range(0, 7)));
  endtask

  // Run with random values on the fields that a run ignores.
  task automatic send_random_run();
    send_item(OP_RUN, PRIO_PORT_W'($urandom_range(0, 63)), LIFE_W'($urandom_range(0, 7)));
  endtask

  // A run straight after reset finds nothing ready.
  task automatic test_empty_run();
    send_item(OP_RUN, '1, '1);
  endtask

  // Field extremes, clamping of level and lifetime, and aging down to level zero.
  task automatic test_field_extremes();
    send_item(OP_CREATE, 6'd0, 3'd0);
    send_item(OP_CREATE, 6'd63, 3'd7);
    send_item(OP_CREATE, 6'd49, 3'd5);
    send_item(OP_CREATE, 6'd50, 3'd6);
    send_item(OP_CREATE, 6'd1, 3'd3);
    while (live_count > 0) send_random_run();
    send_item(OP_RUN, '0, '0);
  endtask

  // Fill the id space until creates are refused, then drain every queue.
  task automatic test_fill_and_drain();
    while (live_count < IDS - 1) send_random_create();
    repeat (3) send_random_create();
    while (live_count > 0) send_random_run();
    repeat (2) send_random_run();
  endtask

  // Phases with different create and run mixes, so the table swings between
  // nearly empty and full.
  task automatic test_random_mix();
    int phase_len;
    int create_pct;
    while (sent_count < TOTAL_ITEMS) begin
      phase_len = $urandom_range(30, 200);
      case ($urandom_range(0, 2))
        0: create_pct = 25;
        1: create_pct = 50;
        default: create_pct = 80;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(1, 100) <= create_pct) begin
          send_random_create();
        end else begin
          send_random_run();
        end
      end
    end
  endtask

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending, task_id", task_id, 0);
      end else begin
        want = pending_results.pop_front();
        if (failed !== want.fail) report_mismatch("failed", failed, want.fail);
        if (task_id !== want.id) report_mismatch("task_id", task_id, want.id);
        if (old_priority !== want.from_level) begin
          report_mismatch("old_priority", old_priority, want.from_level);
        end
        if (new_priority_res !== want.to_level) begin
          report_mismatch("new_priority_res", new_priority_res, want.to_level);
        end
        if (life_left !== want.life) report_mismatch("life_left", life_left, want.life);
        if (retired !== want.retire) report_mismatch("retired", retired, want.retire);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", pending_results.size());
      $display("multilevel_priority_scheduler_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_run();
    test_field_extremes();
    test_fill_and_drain();
    test_random_mix();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d creates (%0d refused on a full id table) and %0d runs", create_count,
             refused_creates, run_count);
    $display("Runs with nothing ready: %0d, tasks retired: %0d, mismatches: %0d", idle_runs,
             retire_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("multilevel_priority_scheduler_unit verification clean");
    end else begin
      $display("multilevel_priority_scheduler_unit verification failed");
    end
    $finish;
  end

endmodule

[multilevel_priority_scheduler_unit.f]
+incdir+hdl
hdl/msched_pkg.sv
hdl/msched_scan.sv
hdl/multilevel_priority_scheduler_unit.sv
bench/multilevel_priority_scheduler_unit_tb.sv
